@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the filter RTL.
// Holds only macro definitions; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("filter logic check failed");

// Expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("filter logic forbidden condition seen");

`endif

@@ rtl/bqf_pkg.sv @@
// Package for the biquad filter: widths, codes, command/status structs and
// the per-step command table of the section sequencer. No dependencies.
package bqf_pkg;

    // Fixed-point formats
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 32;
    localparam int STATE_BITS  = 48;
    localparam int SAMPLE_FRAC = SAMPLE_BITS - 1;
    localparam int COEF_FRAC   = COEF_BITS - 4;
    localparam int STATE_FRAC  = STATE_BITS - 8;
    localparam int IO_SHIFT    = STATE_FRAC - SAMPLE_FRAC;

    // Stream and configuration port widths
    localparam int TDATA_BITS     = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    // Shared multiplier: coefficient (with room for negation) times half a state word
    localparam int COEF_OP_BITS = COEF_BITS + 1;
    localparam int HALF_LO_BITS = STATE_BITS / 2;
    localparam int HALF_OP_BITS = HALF_LO_BITS + 1;
    localparam int PP_BITS      = COEF_OP_BITS + HALF_OP_BITS;
    localparam int PROD_BITS    = COEF_OP_BITS + STATE_BITS;

    // 1.0 in coefficient format
    localparam logic [COEF_BITS-1:0] COEF_ONE =
        {{(COEF_BITS - COEF_FRAC - 1){1'b0}}, 1'b1, {COEF_FRAC{1'b0}}};

    // Input commands (tuser)
    localparam logic CMD_PROCESS = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_B0      = 3'd0,
        REG_B1      = 3'd1,
        REG_B2      = 3'd2,
        REG_A1      = 3'd3,
        REG_A2      = 3'd4,
        REG_CASCADE = 3'd5
    } cfg_reg_t;

    // Sequencer
    localparam int STEP_BITS = 4;
    localparam logic [STEP_BITS-1:0] STEP_LAST = 4'd12;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } ctrl_state_t;

    typedef enum logic [2:0] {
        CSEL_B0,
        CSEL_B1,
        CSEL_B2,
        CSEL_A1,
        CSEL_A2
    } coef_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [2:0] {
        COMB_NONE,
        COMB_Y,
        COMB_LDS,
        COMB_LDU,
        COMB_ADDS,
        COMB_N0,
        COMB_N1
    } comb_op_t;

    typedef struct packed {
        logic      clear;
        logic      load_x;
        logic      cascade_x;
        logic      bank;
        coef_sel_t coef_sel;
        logic      mul_y;
        logic      mul_hi;
        acc_op_t   acc_op;
        logic      rnd_en;
        comb_op_t  comb_op;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic cascade_en;
        logic out_free;
    } dp_status_t;

    // Command with nothing happening
    function automatic dp_cmd_t idle_cmd();
        dp_cmd_t c;
        c          = '0;
        c.coef_sel = CSEL_B0;
        c.acc_op   = ACC_HOLD;
        c.comb_op  = COMB_NONE;
        return c;
    endfunction

    // One section: five products, each as a low and a high half through the
    // multiplier, accumulated, rounded, then folded into y and the history.
    function automatic dp_cmd_t step_cmd(input logic [STEP_BITS-1:0] step);
        dp_cmd_t c;
        c = idle_cmd();
        unique case (step)
            4'd0:  begin c.coef_sel = CSEL_B0; end
            4'd1:  begin c.coef_sel = CSEL_B0; c.mul_hi = 1'b1; c.acc_op = ACC_LOAD; end
            4'd2:  begin c.coef_sel = CSEL_B1; c.acc_op = ACC_ADD; end
            4'd3:  begin
                c.coef_sel = CSEL_B1; c.mul_hi = 1'b1; c.acc_op = ACC_LOAD; c.rnd_en = 1'b1;
            end
            4'd4:  begin c.coef_sel = CSEL_B2; c.acc_op = ACC_ADD; c.comb_op = COMB_Y; end
            4'd5:  begin
                c.coef_sel = CSEL_B2; c.mul_hi = 1'b1; c.acc_op = ACC_LOAD; c.rnd_en = 1'b1;
            end
            4'd6:  begin
                c.coef_sel = CSEL_A1; c.mul_y = 1'b1; c.acc_op = ACC_ADD; c.comb_op = COMB_LDS;
            end
            4'd7:  begin
                c.coef_sel = CSEL_A1; c.mul_y = 1'b1; c.mul_hi = 1'b1;
                c.acc_op   = ACC_LOAD; c.rnd_en = 1'b1;
            end
            4'd8:  begin
                c.coef_sel = CSEL_A2; c.mul_y = 1'b1; c.acc_op = ACC_ADD; c.comb_op = COMB_LDU;
            end
            4'd9:  begin
                c.coef_sel = CSEL_A2; c.mul_y = 1'b1; c.mul_hi = 1'b1;
                c.acc_op   = ACC_LOAD; c.rnd_en = 1'b1;
            end
            4'd10: begin c.acc_op = ACC_ADD; c.comb_op = COMB_ADDS; end
            4'd11: begin c.rnd_en = 1'b1; c.comb_op = COMB_N0; end
            4'd12: begin c.comb_op = COMB_N1; end
            default: begin end
        endcase
        return c;
    endfunction

endpackage

@@ rtl/biquad_iir_filter.sv @@
// Biquad IIR filter, transposed direct form II, fixed point.
// Each sample runs through one section, or two with cascade on; a new one is taken only
// once the previous result is in the output register. A clear is done at its transfer.
// Throughput is set by the single shared 33x25 multiplier: five products per section,
// each in two halves. Output register lets the next sample enter while a result waits.
// Reset (async, active low) zeroes both histories, sets b0 to 1.0, others to 0.
module biquad_iir_filter
    import bqf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [TDATA_BITS-1:0]     s_tdata,   // [23:0] sample_in
    input  logic                      s_tuser,   // [0] command
    input  logic                      s_tlast,
    // output stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [TDATA_BITS-1:0]     m_tdata,   // [23:0] sample_out
    output logic                      m_tlast,
    // configuration
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    dp_cmd_t                cmd;
    dp_status_t             status;
    logic [SAMPLE_BITS-1:0] out_sample;

    // Sequencer
    bqf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and storage
    bqf_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_sample  (s_tdata[SAMPLE_BITS-1:0]),
        .in_last    (s_tlast),
        .m_tready   (m_tready),
        .out_valid  (m_tvalid),
        .out_sample (out_sample),
        .out_last   (m_tlast)
    );

    assign m_tdata = TDATA_BITS'(out_sample);

endmodule

@@ rtl/bqf_dp.sv @@
// Datapath of the biquad filter: coefficient registers, histories, shared
// multiplier, accumulator, rounding and saturating adder, output register.
// Depends on bqf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bqf_dp
    import bqf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_cmd_t                   cmd,
    output dp_status_t                status,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic [SAMPLE_BITS-1:0]    in_sample,
    input  logic                      in_last,
    input  logic                      m_tready,
    output logic                      out_valid,
    output logic [SAMPLE_BITS-1:0]    out_sample,
    output logic                      out_last
);

    localparam int RQ_BITS = PROD_BITS - COEF_FRAC;
    localparam int OQ_BITS = STATE_BITS + 1 - IO_SHIFT;
    localparam logic [STATE_BITS-1:0] STATE_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
    localparam logic [STATE_BITS-1:0] STATE_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [PROD_BITS-1:0] RND_BIAS =
        {{(PROD_BITS-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
    localparam logic [STATE_BITS:0] OUT_BIAS =
        {{(STATE_BITS+1-IO_SHIFT){1'b0}}, 1'b1, {(IO_SHIFT-1){1'b0}}};

    function automatic logic [STATE_BITS-1:0] sat_add(
        input logic [STATE_BITS-1:0] a,
        input logic [STATE_BITS-1:0] b
    );
        logic [STATE_BITS:0] s;
        s = {a[STATE_BITS-1], a} + {b[STATE_BITS-1], b};
        if (s[STATE_BITS] != s[STATE_BITS-1])
            return s[STATE_BITS] ? STATE_MIN : STATE_MAX;
        return s[STATE_BITS-1:0];
    endfunction

    // Registers
    logic [COEF_BITS-1:0]      b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic                      cascade_reg;
    logic [STATE_BITS-1:0]     z0_reg [2];
    logic [STATE_BITS-1:0]     z1_reg [2];
    logic [STATE_BITS-1:0]     x_reg, y_reg, term_reg, s_reg, u_reg;
    logic signed [PP_BITS-1:0] pp_reg;
    logic [PROD_BITS-1:0]      acc_reg;
    logic                      last_reg, out_last_reg, out_valid_reg;
    logic [SAMPLE_BITS-1:0]    out_data_reg;

    // Next values
    logic [STATE_BITS-1:0]          x_next, term_next, sum_next;
    logic signed [PP_BITS-1:0]      pp_next;
    logic [PROD_BITS-1:0]           acc_next;
    logic [SAMPLE_BITS-1:0]         out_data_next;

    // Intermediate signals
    logic [COEF_BITS-1:0]           coef_val;
    logic                           coef_neg;
    logic signed [COEF_OP_BITS-1:0] coef_ext, coef_op;
    logic [STATE_BITS-1:0]          b_src;
    logic signed [HALF_OP_BITS-1:0] half_op;
    logic [PROD_BITS-1:0]           rnd_sum;
    logic [RQ_BITS-1:0]             rnd_q;
    logic [STATE_BITS-1:0]          add_a, add_b;
    logic [STATE_BITS:0]            o_sum;
    logic [OQ_BITS-1:0]             o_q;

    // Sample into state precision
    assign x_next = {{(STATE_BITS-SAMPLE_BITS-IO_SHIFT){in_sample[SAMPLE_BITS-1]}},
                     in_sample, {IO_SHIFT{1'b0}}};

    // Coefficient operand, negated for the feedback terms
    always_comb
    begin
        unique case (cmd.coef_sel)
            CSEL_B0: coef_val = b0_reg;
            CSEL_B1: coef_val = b1_reg;
            CSEL_B2: coef_val = b2_reg;
            CSEL_A1: coef_val = a1_reg;
            CSEL_A2: coef_val = a2_reg;
            default: coef_val = b0_reg;
        endcase
        coef_neg = (cmd.coef_sel == CSEL_A1) || (cmd.coef_sel == CSEL_A2);
        coef_ext = COEF_OP_BITS'($signed(coef_val));
        coef_op  = coef_neg ? -coef_ext : coef_ext;
    end

    // Half-word operand: unsigned low half or signed high half
    always_comb
    begin
        b_src = cmd.mul_y ? y_reg : x_reg;
        if (cmd.mul_hi)
            half_op = HALF_OP_BITS'($signed(b_src[STATE_BITS-1:HALF_LO_BITS]));
        else
            half_op = $signed(HALF_OP_BITS'({1'b0, b_src[HALF_LO_BITS-1:0]}));
    end

    assign pp_next = coef_op * half_op;

    // Accumulate the two halves into the full product
    always_comb
    begin
        unique case (cmd.acc_op)
            ACC_LOAD: acc_next = PROD_BITS'(pp_reg);
            ACC_ADD:  acc_next = acc_reg + (PROD_BITS'(pp_reg) << HALF_LO_BITS);
            default:  acc_next = acc_reg;
        endcase
    end

    // Round half away from zero, drop fraction, saturate to state width
    always_comb
    begin
        rnd_sum = acc_reg + RND_BIAS - PROD_BITS'(acc_reg[PROD_BITS-1]);
        rnd_q   = rnd_sum[PROD_BITS-1:COEF_FRAC];
        if ((&rnd_q[RQ_BITS-1:STATE_BITS-1]) || !(|rnd_q[RQ_BITS-1:STATE_BITS-1]))
            term_next = rnd_q[STATE_BITS-1:0];
        else
            term_next = rnd_q[RQ_BITS-1] ? STATE_MIN : STATE_MAX;
    end

    // Shared saturating adder
    always_comb
    begin
        unique case (cmd.comb_op)
            COMB_Y:  begin add_a = term_reg; add_b = z0_reg[cmd.bank]; end
            COMB_N0: begin add_a = s_reg;    add_b = z1_reg[cmd.bank]; end
            COMB_N1: begin add_a = u_reg;    add_b = term_reg;         end
            default: begin add_a = s_reg;    add_b = term_reg;         end
        endcase
        sum_next = sat_add(add_a, add_b);
    end

    // Result back to sample precision
    always_comb
    begin
        o_sum = {y_reg[STATE_BITS-1], y_reg} + OUT_BIAS
                - (STATE_BITS+1)'(y_reg[STATE_BITS-1]);
        o_q   = o_sum[STATE_BITS:IO_SHIFT];
        if ((&o_q[OQ_BITS-1:SAMPLE_BITS-1]) || !(|o_q[OQ_BITS-1:SAMPLE_BITS-1]))
            out_data_next = o_q[SAMPLE_BITS-1:0];
        else
            out_data_next = o_q[OQ_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end

    // Configuration, history and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg        <= COEF_ONE;
            b1_reg        <= '0;
            b2_reg        <= '0;
            a1_reg        <= '0;
            a2_reg        <= '0;
            cascade_reg   <= 1'b0;
            z0_reg[0]     <= '0;
            z0_reg[1]     <= '0;
            z1_reg[0]     <= '0;
            z1_reg[1]     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_B0:      b0_reg      <= cfg_data[COEF_BITS-1:0];
                    REG_B1:      b1_reg      <= cfg_data[COEF_BITS-1:0];
                    REG_B2:      b2_reg      <= cfg_data[COEF_BITS-1:0];
                    REG_A1:      a1_reg      <= cfg_data[COEF_BITS-1:0];
                    REG_A2:      a2_reg      <= cfg_data[COEF_BITS-1:0];
                    REG_CASCADE: cascade_reg <= cfg_data[0];
                    default:     begin end
                endcase
            end

            if (cmd.clear)
            begin
                z0_reg[0] <= '0;
                z0_reg[1] <= '0;
                z1_reg[0] <= '0;
                z1_reg[1] <= '0;
            end
            else if (cmd.comb_op == COMB_N0)
                z0_reg[cmd.bank] <= sum_next;
            else if (cmd.comb_op == COMB_N1)
                z1_reg[cmd.bank] <= sum_next;

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        pp_reg  <= pp_next;
        acc_reg <= acc_next;
        if (cmd.rnd_en)
            term_reg <= term_next;

        if (cmd.load_x)
        begin
            x_reg    <= x_next;
            last_reg <= in_last;
        end
        else if (cmd.cascade_x)
            x_reg <= y_reg;

        unique case (cmd.comb_op)
            COMB_Y:    y_reg <= sum_next;
            COMB_LDS:  s_reg <= term_reg;
            COMB_LDU:  u_reg <= term_reg;
            COMB_ADDS: s_reg <= sum_next;
            default:   begin end
        endcase

        if (cmd.out_load)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= last_reg;
        end
    end

    assign status.cascade_en = cascade_reg;
    assign status.out_free   = !out_valid_reg || m_tready;
    assign out_valid         = out_valid_reg;
    assign out_sample        = out_data_reg;
    assign out_last          = out_last_reg;

    `ASSERT_NEVER(a_out_overwrite, clk, rst_n, cmd.out_load && out_valid_reg && !m_tready)
    `ASSERT_AT(a_clear_zeroes, clk, rst_n, $past(cmd.clear) |-> (z0_reg[0] == '0 && z0_reg[1] == '0 && z1_reg[0] == '0 && z1_reg[1] == '0))

endmodule

@@ rtl/bqf_ctrl.sv @@
// Controller of the biquad filter: takes input transfers, steps the section
// schedule once or twice per sample and hands the result to the output stage.
// Depends on bqf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bqf_ctrl
    import bqf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tuser,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t          state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 sec_reg, sec_next;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            sec_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sec_reg   <= sec_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        sec_next   = sec_reg;
        s_tready   = 1'b0;
        cmd        = idle_cmd();

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == CMD_CLEAR)
                        cmd.clear = 1'b1;
                    else
                    begin
                        cmd.load_x = 1'b1;
                        state_next = ST_RUN;
                        step_next  = '0;
                        sec_next   = 1'b0;
                    end
                end
            end

            ST_RUN:
            begin
                cmd      = step_cmd(step_reg);
                cmd.bank = sec_reg;
                if (step_reg == STEP_LAST)
                begin
                    // second section takes the first one's output
                    if (!sec_reg && status.cascade_en)
                    begin
                        cmd.cascade_x = 1'b1;
                        sec_next      = 1'b1;
                        step_next     = '0;
                    end
                    else
                        state_next = ST_FINISH;
                end
                else
                    step_next = STEP_BITS'(step_reg + 1'b1);
            end

            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    `ASSERT_AT(a_step_range, clk, rst_n, (state_reg == ST_RUN) |-> (step_reg <= STEP_LAST))
    `ASSERT_AT(a_start, clk, rst_n, (state_reg == ST_IDLE && s_tvalid && s_tuser == CMD_PROCESS) |=> (state_reg == ST_RUN && step_reg == '0 && !sec_reg))
    `ASSERT_AT(a_second_after_first, clk, rst_n, $rose(sec_reg) |-> ($past(step_reg) == STEP_LAST))

endmodule

@@ tb/biquad_iir_filter_tb.sv @@
// Self-checking testbench for the biquad IIR filter: directed table, then
// randomised coefficient settings with stalls on both stream sides.
// Depends on bqf_pkg and the biquad_iir_filter RTL.
module biquad_iir_filter_tb;
    import bqf_pkg::*;

    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int IDLE_SETTLE = 40;    // covers the cascade latency
    localparam int STALL_LIMIT = 3000;  // watchdog, cycles without a transfer
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 53;
    localparam int BURST_ITEMS = 30;
    localparam int REPORT_MAX  = 10;

    localparam logic [CFG_INDEX_BITS-1:0] NO_REG      = 3'd0;  // unused field
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 3'd7;

    localparam logic signed [63:0] STATE_MAX = (64'sd1 <<< (STATE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] STATE_MIN = -STATE_MAX - 64'sd1;

    typedef enum logic { DIR_ITEM, DIR_CFG } dir_kind_t;

    typedef struct packed {
        dir_kind_t                 kind;
        logic                      cmd;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  value;   // register data, or sample in low bits
        logic                      last;
        logic                      check;   // expected output typed in
        logic [SAMPLE_BITS-1:0]    known;
    } dir_row_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last;
    } out_sample_t;

    localparam int DIR_ROWS = 39;

    // Directed table: identity after reset, saturating gains, spare indexes,
    // extreme feedback with and without cascade, clears
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h007F_FFFF, 1'b0, 1'b1, 24'h7F_FFFF},
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h0080_0000, 1'b1, 1'b1, 24'h80_0000},
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h0000_0000, 1'b0, 1'b1, 24'h00_0000},
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h0000_0001, 1'b0, 1'b1, 24'h00_0001},
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h00FF_FFFF, 1'b1, 1'b1, 24'hFF_FFFF},
        '{DIR_ITEM, CMD_CLEAR,   NO_REG, 32'h00A5_A5A5, 1'b1, 1'b0, 24'h00_0000},
        '{DIR_CFG,  CMD_PROCESS, REG_B0, 32'h7FFF_FFFF, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h007F_FFFF, 1'b0, 1'b1, 24'h7F_FFFF},
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h0080_0000, 1'b1, 1'b1, 24'h80_0000},
        '{DIR_CFG,  CMD_PROCESS, REG_SPARE_A, 32'h0000_0000, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_CFG,  CMD_PROCESS, REG_SPARE_B, 32'hFFFF_FFFF, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h0040_0000, 1'b0, 1'b1, 24'h7F_FFFF},
        '{DIR_CFG,  CMD_PROCESS, REG_B1, 32'h8000_0000, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_CFG,  CMD_PROCESS, REG_B2, 32'h7FFF_FFFF, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_CFG,  CMD_PROCESS, REG_A1, 32'h8000_0000, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_CFG,  CMD_PROCESS, REG_A2, 32'h7FFF_FFFF, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h007F_FFFF, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h0080_0000, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h007F_FFFF, 1'b1, 1'b0, 24'h00_0000},
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h0012_3456, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_CFG,  CMD_PROCESS, REG_CASCADE, 32'h0000_0001, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h007F_FFFF, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h0080_0000, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h0000_0001, 1'b1, 1'b0, 24'h00_0000},
        '{DIR_ITEM, CMD_CLEAR,   NO_REG, 32'h00FF_FFFF, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h007F_FFFF, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h0080_0000, 1'b1, 1'b0, 24'h00_0000},
        '{DIR_CFG,  CMD_PROCESS, REG_B0, 32'h8000_0000, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_CFG,  CMD_PROCESS, REG_B1, 32'h7FFF_FFFF, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_CFG,  CMD_PROCESS, REG_B2, 32'h8000_0000, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_CFG,  CMD_PROCESS, REG_A1, 32'h7FFF_FFFF, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_CFG,  CMD_PROCESS, REG_A2, 32'h8000_0000, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h0080_0000, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h007F_FFFF, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h0000_0000, 1'b1, 1'b0, 24'h00_0000},
        '{DIR_CFG,  CMD_PROCESS, REG_CASCADE, 32'h0000_0000, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h007F_FFFF, 1'b0, 1'b0, 24'h00_0000},
        '{DIR_ITEM, CMD_PROCESS, NO_REG, 32'h0080_0000, 1'b1, 1'b0, 24'h00_0000},
        '{DIR_ITEM, CMD_CLEAR,   NO_REG, 32'h0000_0000, 1'b1, 1'b0, 24'h00_0000}
    };

    // DUT connections, inputs driven from time zero
    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [TDATA_BITS-1:0]     s_tdata   = '0;   // [23:0] sample_in
    logic                      s_tuser   = CMD_PROCESS;   // [0] command
    logic                      s_tlast   = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [TDATA_BITS-1:0]     m_tdata;          // [23:0] sample_out
    logic                      m_tlast;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = NO_REG;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // Predictor copy of registers and the two section histories
    logic signed [COEF_BITS-1:0]  coef_b0 = COEF_ONE;
    logic signed [COEF_BITS-1:0]  coef_b1 = '0;
    logic signed [COEF_BITS-1:0]  coef_b2 = '0;
    logic signed [COEF_BITS-1:0]  coef_a1 = '0;
    logic signed [COEF_BITS-1:0]  coef_a2 = '0;
    logic                         cascade_on = 1'b0;
    logic signed [STATE_BITS-1:0] history [2][2] = '{default: '0};

    out_sample_t filtered_due [$];
    out_sample_t due_head;

    // Run bookkeeping
    bit stream_open     = 1'b0;
    bit block_quiet     = 1'b1;
    bit idle_mode       = 1'b1;
    int hold_req_count  = 0;
    int hold_done_count = 0;
    int hold_left       = 0;
    int ready_gap       = 0;
    int samples_sent    = 0;
    int clears_sent     = 0;
    int outputs_seen    = 0;
    int settings_used   = 1;
    int mismatches      = 0;

    biquad_iir_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // round(a*b / 2^shift), ties away from zero, optionally negated, saturated
    function automatic logic signed [63:0] round_product(input logic signed [63:0] a,
                                                         input logic signed [63:0] b,
                                                         input int shift, input int width,
                                                         input bit flip);
        logic [127:0] mag_a;
        logic [127:0] mag_b;
        logic [127:0] prod;
        logic [127:0] limit;
        bit           neg;
        neg   = ((a < 0) != (b < 0)) != flip;
        mag_a = (a < 0) ? 128'(-a) : 128'(a);
        mag_b = (b < 0) ? 128'(-b) : 128'(b);
        prod  = (mag_a * mag_b + (128'd1 << (shift - 1))) >> shift;
        limit = (128'd1 << (width - 1)) - (neg ? 128'd0 : 128'd1);
        if (prod > limit)
            prod = limit;
        return neg ? -$signed(prod[63:0]) : $signed(prod[63:0]);
    endfunction

    function automatic logic signed [63:0] state_add(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (s > STATE_MAX)
            return STATE_MAX;
        if (s < STATE_MIN)
            return STATE_MIN;
        return s;
    endfunction

    // One transposed direct form II section; bank 0 first, bank 1 cascade
    function automatic logic signed [63:0] biquad_section(input int bank,
                                                          input logic signed [63:0] x);
        logic signed [63:0] y;
        logic signed [63:0] n0;
        logic signed [63:0] n1;
        y  = state_add(round_product(coef_b0, x, COEF_FRAC, STATE_BITS, 1'b0),
                       history[bank][0]);
        n0 = state_add(state_add(round_product(coef_b1, x, COEF_FRAC, STATE_BITS, 1'b0),
                                 round_product(coef_a1, y, COEF_FRAC, STATE_BITS, 1'b1)),
                       history[bank][1]);
        n1 = state_add(round_product(coef_b2, x, COEF_FRAC, STATE_BITS, 1'b0),
                       round_product(coef_a2, y, COEF_FRAC, STATE_BITS, 1'b1));
        history[bank][0] = n0[STATE_BITS-1:0];
        history[bank][1] = n1[STATE_BITS-1:0];
        return y;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] biquad_predict(
            input logic signed [SAMPLE_BITS-1:0] smp);
        logic signed [63:0] v;
        v = round_product(smp, 64'sd1 <<< STATE_FRAC, SAMPLE_FRAC, STATE_BITS, 1'b0);
        v = biquad_section(0, v);
        if (cascade_on)
            v = biquad_section(1, v);
        v = round_product(v, 64'sd1 <<< SAMPLE_FRAC, STATE_FRAC, SAMPLE_BITS, 1'b0);
        return v[SAMPLE_BITS-1:0];
    endfunction

    // Gap length: mostly short, a few long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int next_send_gap();
        if (!idle_mode || $urandom_range(0, 1) == 0)
            return 0;
        return idle_gap();
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 15))
            0:       return 24'h7F_FFFF;
            1:       return 24'h80_0000;
            2:       return 24'h00_0000;
            3:       return {{16{r[8]}}, r[7:0]};
            default: return r[SAMPLE_BITS-1:0];
        endcase
    endfunction

    // Coefficient families: full range, within +-0.5, extremes, near identity
    function automatic logic [COEF_BITS-1:0] pick_coef(input int family, input bit lead);
        logic [31:0] r;
        r = $urandom();
        case (family)
            0: return r;
            1: return {{4{r[27]}}, r[27:0]};
            2:
            begin
                case ($urandom_range(0, 6))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    3:       return COEF_ONE;
                    4:       return -COEF_ONE;
                    5:       return 32'h0000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return lead ? COEF_ONE + {{12{r[19]}}, r[19:0]} : {{12{r[19]}}, r[19:0]};
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("Mismatch on %s at %0t: expected %h, got %h", what, $time, want, got);
    endtask

    // Register write, mirrored into the predictor; spare indexes change nothing
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_B0:      coef_b0 = data;
            REG_B1:      coef_b1 = data;
            REG_B2:      coef_b2 = data;
            REG_A1:      coef_a1 = data;
            REG_A2:      coef_a2 = data;
            REG_CASCADE: cascade_on = data[0];
            default:     ;
        endcase
    endtask

    // Offer one item after a gap and wait for its transfer
    task automatic send_item(input logic cmd, input logic [SAMPLE_BITS-1:0] smp,
                             input logic last, input logic check,
                             input logic [SAMPLE_BITS-1:0] known, input int gap);
        out_sample_t due;
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid    <= 1'b1;
        s_tuser     <= cmd;
        s_tdata     <= smp;
        s_tlast     <= last;
        stream_open = 1'b1;
        block_quiet = 1'b0;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (cmd == CMD_CLEAR)
        begin
            history = '{default: '0};
            clears_sent++;
        end
        else
        begin
            due.sample = biquad_predict(smp);
            if (check)
                due.sample = known;
            due.last = last;
            filtered_due.push_back(due);
            samples_sent++;
        end
    endtask

    // Stop offering, let every output arrive, then allow for a trailing clear
    task automatic settle_for_config();
        if (!block_quiet)
        begin
            if (stream_open)
            begin
                @(negedge clk);
                s_tvalid    <= 1'b0;
                stream_open = 1'b0;
            end
            while (filtered_due.size() != 0)
                @(posedge clk);
            repeat (IDLE_SETTLE) @(posedge clk);
            block_quiet = 1'b1;
            settings_used++;
        end
    endtask

    // Receiver: random back-pressure, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_done_count != hold_req_count)
        begin
            hold_done_count = hold_req_count;
            hold_left       = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (ready_gap != 0)
        begin
            m_tready <= 1'b0;
            ready_gap--;
        end
        else
        begin
            m_tready <= 1'b1;
            if (idle_mode && $urandom_range(0, 3) == 0)
                ready_gap = idle_gap();
        end
    end

    // Output checker: each transfer against the oldest expected sample
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            outputs_seen++;
            if (filtered_due.size() == 0)
                note_mismatch("output with none outstanding", '0, m_tdata);
            else
            begin
                due_head = filtered_due.pop_front();
                if (m_tdata[SAMPLE_BITS-1:0] !== due_head.sample)
                    note_mismatch("sample_out", due_head.sample, m_tdata[SAMPLE_BITS-1:0]);
                if (m_tlast !== due_head.last)
                    note_mismatch("block_end_out", due_head.last, m_tlast);
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Stimulus
    initial
    begin
        int                     i;
        int                     p;
        int                     n;
        int                     family;
        int                     gap;
        int                     block_left;
        bit                     burst;
        logic                   cmd;
        logic                   last;
        logic [SAMPLE_BITS-1:0] no_sample;
        block_left = 0;
        no_sample  = '0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (directed_rows[i].kind == DIR_CFG)
            begin
                settle_for_config();
                write_reg(directed_rows[i].idx, directed_rows[i].value);
            end
            else
                send_item(directed_rows[i].cmd, directed_rows[i].value[SAMPLE_BITS-1:0],
                          directed_rows[i].last, directed_rows[i].check,
                          directed_rows[i].known, next_send_gap());
        end

        // Random phases, each with a fresh coefficient setting
        for (p = 0; p < PHASES; p++)
        begin
            settle_for_config();
            family = p % 4;
            write_reg(REG_B0, pick_coef(family, 1'b1));
            write_reg(REG_B1, pick_coef(family, 1'b0));
            write_reg(REG_B2, pick_coef(family, 1'b0));
            write_reg(REG_A1, pick_coef(family, 1'b0));
            write_reg(REG_A2, pick_coef(family, 1'b0));
            write_reg(REG_CASCADE, (p == 0) ? 32'd0 : (p == 1) ? 32'd1 : $urandom());
            if (p % 3 == 2)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom());
            idle_mode = !(p == 3 || p == 7);
            burst     = (p == 2 || p == 6);
            // receiver holds off while the sender keeps offering back to back
            if (burst)
                hold_req_count++;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                gap = (burst && n < BURST_ITEMS) ? 0 : next_send_gap();
                cmd = ($urandom_range(0, 15) == 0) ? CMD_CLEAR : CMD_PROCESS;
                if (block_left == 0)
                begin
                    last       = 1'b1;
                    block_left = $urandom_range(0, 15);
                end
                else
                begin
                    last = 1'b0;
                    block_left--;
                end
                send_item(cmd, random_sample(), last, 1'b0, no_sample, gap);
            end
        end

        settle_for_config();
        $display("Sent %0d samples and %0d history clears over %0d coefficient settings,",
                 samples_sent, clears_sent, settings_used);
        $display("cascade on and off; %0d outputs compared, %0d mismatches.",
                 outputs_seen, mismatches);
        if (mismatches == 0 && filtered_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/bqf_pkg.sv
rtl/bqf_dp.sv
rtl/bqf_ctrl.sv
rtl/biquad_iir_filter.sv
tb/biquad_iir_filter_tb.sv
